// ===== src/mse_pkg.sv =====
// ----------------------------------------------------------------------------
// mse_pkg
// Shared constants and types for the MIPS subset execute block: opcode and
// function codes, reset values, and the structs that pass between modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mse_pkg;

  // Sizes and reset values
  localparam int          DATA_BYTES_DEF = 8192;
  localparam int          REG_COUNT      = 32;
  localparam int          REG_AW         = $clog2(REG_COUNT);
  localparam logic [31:0] CODE_START_RST = 32'h0040_0000;
  localparam logic [31:0] DATA_BASE_RST  = 32'h1001_0000;

  // Configuration register indexes
  localparam logic CFG_CODE_START = 1'b0;
  localparam logic CFG_DATA_BASE  = 1'b1;

  // Primary opcodes
  localparam logic [5:0] OP_SPECIAL = 6'd0;
  localparam logic [5:0] OP_J       = 6'd2;
  localparam logic [5:0] OP_JAL     = 6'd3;
  localparam logic [5:0] OP_BEQ     = 6'd4;
  localparam logic [5:0] OP_BNE     = 6'd5;
  localparam logic [5:0] OP_ADDI    = 6'd8;
  localparam logic [5:0] OP_ADDIU   = 6'd9;
  localparam logic [5:0] OP_SLTI    = 6'd10;
  localparam logic [5:0] OP_SLTIU   = 6'd11;
  localparam logic [5:0] OP_ANDI    = 6'd12;
  localparam logic [5:0] OP_ORI     = 6'd13;
  localparam logic [5:0] OP_XORI    = 6'd14;
  localparam logic [5:0] OP_LUI     = 6'd15;
  localparam logic [5:0] OP_LB      = 6'd32;
  localparam logic [5:0] OP_LH      = 6'd33;
  localparam logic [5:0] OP_LW      = 6'd35;
  localparam logic [5:0] OP_SB      = 6'd40;
  localparam logic [5:0] OP_SH      = 6'd41;
  localparam logic [5:0] OP_SW      = 6'd43;

  // SPECIAL function codes
  localparam logic [5:0] FN_SLL     = 6'h00;
  localparam logic [5:0] FN_SRL     = 6'h02;
  localparam logic [5:0] FN_JR      = 6'h08;
  localparam logic [5:0] FN_SYSCALL = 6'h0C;
  localparam logic [5:0] FN_ADD     = 6'h20;
  localparam logic [5:0] FN_ADDU    = 6'h21;
  localparam logic [5:0] FN_SUB     = 6'h22;
  localparam logic [5:0] FN_AND     = 6'h24;
  localparam logic [5:0] FN_OR      = 6'h25;
  localparam logic [5:0] FN_XOR     = 6'h26;
  localparam logic [5:0] FN_SLT     = 6'h2A;

  // Syscall service codes and fixed registers
  localparam logic [31:0]       SYS_PRINT_INT = 32'd1;
  localparam logic [31:0]       SYS_EXIT      = 32'd10;
  localparam logic [REG_AW-1:0] REG_V0        = 5'd2;
  localparam logic [REG_AW-1:0] REG_A0        = 5'd4;
  localparam logic [REG_AW-1:0] REG_RA        = 5'd31;

  // Register file write
  typedef struct packed {
    logic              we;
    logic [REG_AW-1:0] addr;
    logic [31:0]       data;
  } rf_wr_t;

  // Data memory request controls
  typedef struct packed {
    logic       rd;
    logic       wr;
    logic [2:0] size;
  } dm_req_t;

endpackage

`default_nettype wire

// ===== src/mse_regfile.sv =====
// ----------------------------------------------------------------------------
// mse_regfile
// Register file with two read ports built as two mirrored synchronous
// memories. Valid bits make unwritten entries read zero after reset; a
// bypass register covers a read and write of the same entry at one edge.
// ----------------------------------------------------------------------------
`default_nettype none

module mse_regfile
  import mse_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              rd_en,
  input  wire logic [REG_AW-1:0] ra,
  input  wire logic [REG_AW-1:0] rb,
  input  wire rf_wr_t            wr,
  output logic [31:0]            a,
  output logic [31:0]            b
);

  logic [31:0]          mem_a [REG_COUNT];
  logic [31:0]          mem_b [REG_COUNT];
  logic [REG_COUNT-1:0] valid;
  logic [31:0]          qa, qb;
  logic                 va, vb;
  logic [REG_AW-1:0]    ra_q, rb_q;
  logic                 byp_vld;
  logic [REG_AW-1:0]    byp_addr;
  logic [31:0]          byp_data;
  logic                 wen;

  assign wen = wr.we && (wr.addr != '0);

  // Write both copies; register zero is never written
  always_ff @(posedge clk) begin
    if (wen) begin
      mem_a[wr.addr] <= wr.data;
      mem_b[wr.addr] <= wr.data;
    end
  end

  // Track written entries and the most recent write
  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      byp_vld <= 1'b0;
    end else if (wen) begin
      valid[wr.addr] <= 1'b1;
      byp_vld        <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wen) begin
      byp_addr <= wr.addr;
      byp_data <= wr.data;
    end
  end

  // Registered reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      qa   <= mem_a[ra];
      qb   <= mem_b[rb];
      va   <= valid[ra];
      vb   <= valid[rb];
      ra_q <= ra;
      rb_q <= rb;
    end
  end

  // Select bypass, memory or zero
  always_comb begin
    if (ra_q == '0)                           a = '0;
    else if (byp_vld && (byp_addr == ra_q))   a = byp_data;
    else if (va)                              a = qa;
    else                                      a = '0;
    if (rb_q == '0)                           b = '0;
    else if (byp_vld && (byp_addr == rb_q))   b = byp_data;
    else if (vb)                              b = qb;
    else                                      b = '0;
  end

endmodule

`default_nettype wire

// ===== src/mse_dmem.sv =====
// ----------------------------------------------------------------------------
// mse_dmem
// Big-endian byte data memory in four byte-lane banks, so that any access of
// up to four bytes at any alignment uses each bank at most once. A clearing
// pass after reset zeroes one row of all banks per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mse_dmem
  import mse_pkg::*;
#(
  parameter int DATA_BYTES = DATA_BYTES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  output logic                               busy,
  input  wire dm_req_t                       req,
  input  wire logic [$clog2(DATA_BYTES)-1:0] off,
  input  wire logic [31:0]                   wdata,
  output logic [31:0]                        rdata
);

  localparam int AW   = $clog2(DATA_BYTES);
  localparam int ROWS = (DATA_BYTES + 3) / 4;
  localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;

  logic          clearing;
  logic [RW-1:0] clr_row;
  logic [1:0]    lo_q;
  logic [7:0]    q [4];
  logic [31:0]   wl;

  assign busy = clearing;

  // Left-align the store bytes: byte j of the access is wl[31-8j -: 8]
  assign wl = wdata << (8 * (3'd4 - req.size));

  // Sweep all rows after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_row  <= '0;
    end else if (clearing) begin
      clr_row <= clr_row + 1'b1;
      if (clr_row == RW'(ROWS - 1)) clearing <= 1'b0;
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_bank
    logic [7:0]    mem [ROWS];
    logic [1:0]    j;
    logic [AW:0]   sum;
    logic [RW-1:0] row;
    logic [31:0]   sh;
    logic          we;

    // Byte j of the access falls in this bank
    assign j   = 2'(k) - off[1:0];
    assign sum = {1'b0, off} + (AW+1)'(j);
    assign row = RW'(sum >> 2);
    assign sh  = wl << (8 * j);
    assign we  = req.wr && ({1'b0, j} < req.size);

    // Write: clearing pass or store
    always_ff @(posedge clk) begin
      if (clearing) mem[clr_row] <= '0;
      else if (we)  mem[row] <= sh[31:24];
    end

    // Registered read
    always_ff @(posedge clk) begin
      if (req.rd) q[k] <= mem[row];
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd) lo_q <= off[1:0];
  end

  // Reassemble bytes in access order
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      rdata[31-8*j -: 8] = q[2'(lo_q + 2'(j))];
    end
  end

endmodule

`default_nettype wire

// ===== src/mips_subset_execute.sv =====
// ----------------------------------------------------------------------------
// mips_subset_execute
// Executes one MIPS32 integer instruction per input transaction and returns
// one result transaction (next PC, print event, exit, memory fault).
// ----------------------------------------------------------------------------
// Timing: an instruction is taken and its registers read; the execute stage
// then executes it and writes back once the output is free, so ALU, branch,
// jump, store and syscall instructions sustain one per cycle while out_stall
// is low. Loads issue a data memory read and write back from a load stage; no
// input is taken until the load finishes. After reset data memory is cleared
// one four-byte row per cycle while input is stalled; configuration writes are
// taken at any time but must be made while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module mips_subset_execute
  import mse_pkg::*;
#(
  parameter int DATA_BYTES = DATA_BYTES_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_write,
  input  wire logic         cfg_index,
  input  wire logic [31:0]  cfg_data,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire logic [31:0]  instr_word,
  output logic              out_valid,
  input  wire logic         out_stall,
  output logic [31:0]       next_pc,
  output logic              print_valid,
  output logic signed [31:0] print_value,
  output logic              halted,
  output logic              mem_fault
);

  localparam int AW = $clog2(DATA_BYTES);

  logic              busy;
  logic [31:0]       pc, data_base;
  logic              ex_valid, ld_valid;
  logic [31:0]       ir;
  logic [31:0]       a, b;
  logic              accept, fin_ok, ex_fin, ex_to_ld, ld_fin;
  logic [REG_AW-1:0] ra, rb;
  rf_wr_t            rf_wr, ex_wr;
  dm_req_t           dreq;
  logic [31:0]       rdata;

  // Execute-stage decode and results
  logic [5:0]        op, fn;
  logic [REG_AW-1:0] rt, rd;
  logic [4:0]        shamt;
  logic [31:0]       imm, simm, seq, npc, addr, off32;
  logic              is_load, is_store, bad, pv, halt;
  logic [31:0]       pval;
  logic [2:0]        size;

  // Load stage
  logic [REG_AW-1:0] ld_rt;
  logic [5:0]        ld_op;
  logic              ld_bad;
  logic [31:0]       ld_npc, ld_data;

  // Handshake
  assign fin_ok   = !out_valid || !out_stall;
  assign ex_fin   = ex_valid && !is_load && fin_ok;
  assign ex_to_ld = ex_valid && is_load;
  assign ld_fin   = ld_valid && fin_ok;
  assign in_stall = busy || !((!ex_valid && !ld_valid) || ex_fin || ld_fin);
  assign accept   = in_valid && !in_stall;

  // Register read addresses: syscall reads v0 and a0
  always_comb begin
    if ((instr_word[31:26] == OP_SPECIAL) && (instr_word[5:0] == FN_SYSCALL)) begin
      ra = REG_V0;
      rb = REG_A0;
    end else begin
      ra = instr_word[25:21];
      rb = instr_word[20:16];
    end
  end

  mse_regfile u_regfile (
    .clk   (clk),
    .rst   (rst),
    .rd_en (accept),
    .ra    (ra),
    .rb    (rb),
    .wr    (rf_wr),
    .a     (a),
    .b     (b)
  );

  // Decode and execute
  always_comb begin
    op       = ir[31:26];
    rt       = ir[20:16];
    rd       = ir[15:11];
    shamt    = ir[10:6];
    fn       = ir[5:0];
    imm      = {16'h0000, ir[15:0]};
    simm     = {{16{ir[15]}}, ir[15:0]};
    seq      = pc + 32'd4;
    npc      = seq;
    addr     = a + simm;
    off32    = addr - data_base;
    pv       = 1'b0;
    pval     = '0;
    halt     = 1'b0;
    ex_wr    = '0;
    is_load  = 1'b0;
    is_store = 1'b0;
    size     = 3'd4;
    unique case (op)
      OP_SPECIAL: begin
        ex_wr.addr = rd;
        unique case (fn)
          FN_ADD, FN_ADDU: begin ex_wr.we = 1'b1; ex_wr.data = a + b; end
          FN_SUB:          begin ex_wr.we = 1'b1; ex_wr.data = a - b; end
          FN_AND:          begin ex_wr.we = 1'b1; ex_wr.data = a & b; end
          FN_OR:           begin ex_wr.we = 1'b1; ex_wr.data = a | b; end
          FN_XOR:          begin ex_wr.we = 1'b1; ex_wr.data = a ^ b; end
          FN_SLT: begin
            ex_wr.we   = 1'b1;
            ex_wr.data = {31'd0, $signed(a) < $signed(b)};
          end
          FN_SLL:          begin ex_wr.we = 1'b1; ex_wr.data = b << shamt; end
          FN_SRL:          begin ex_wr.we = 1'b1; ex_wr.data = b >> shamt; end
          FN_JR:           npc = a;
          FN_SYSCALL: begin
            if (a == SYS_PRINT_INT) begin
              pv   = 1'b1;
              pval = b;
            end else if (a == SYS_EXIT) begin
              halt = 1'b1;
            end
          end
          default: ;
        endcase
      end
      OP_J, OP_JAL: begin
        ex_wr.we   = (op == OP_JAL);
        ex_wr.addr = REG_RA;
        ex_wr.data = seq;
        npc        = {seq[31:28], ir[25:0], 2'b00};
      end
      OP_BEQ: if (a == b) npc = seq + {simm[29:0], 2'b00};
      OP_BNE: if (a != b) npc = seq + {simm[29:0], 2'b00};
      OP_ADDI, OP_ADDIU: begin ex_wr.we = 1'b1; ex_wr.addr = rt; ex_wr.data = a + simm; end
      OP_SLTI: begin
        ex_wr.we   = 1'b1;
        ex_wr.addr = rt;
        ex_wr.data = {31'd0, $signed(a) < $signed(simm)};
      end
      OP_SLTIU: begin ex_wr.we = 1'b1; ex_wr.addr = rt; ex_wr.data = {31'd0, a < simm}; end
      OP_ANDI:  begin ex_wr.we = 1'b1; ex_wr.addr = rt; ex_wr.data = a & imm; end
      OP_ORI:   begin ex_wr.we = 1'b1; ex_wr.addr = rt; ex_wr.data = a | imm; end
      OP_XORI:  begin ex_wr.we = 1'b1; ex_wr.addr = rt; ex_wr.data = a ^ imm; end
      OP_LUI:   begin ex_wr.we = 1'b1; ex_wr.addr = rt; ex_wr.data = {ir[15:0], 16'h0000}; end
      OP_LB:    begin is_load  = 1'b1; size = 3'd1; end
      OP_LH:    begin is_load  = 1'b1; size = 3'd2; end
      OP_LW:    begin is_load  = 1'b1; size = 3'd4; end
      OP_SB:    begin is_store = 1'b1; size = 3'd1; end
      OP_SH:    begin is_store = 1'b1; size = 3'd2; end
      OP_SW:    begin is_store = 1'b1; size = 3'd4; end
      default: ;
    endcase
    bad = (is_load || is_store) && (off32 > (32'(DATA_BYTES) - 32'(size)));
  end

  // Data memory requests
  always_comb begin
    dreq.rd   = ex_valid && is_load && !bad;
    dreq.wr   = ex_valid && is_store && !bad && fin_ok;
    dreq.size = size;
  end

  mse_dmem #(
    .DATA_BYTES (DATA_BYTES)
  ) u_dmem (
    .clk   (clk),
    .rst   (rst),
    .busy  (busy),
    .req   (dreq),
    .off   (off32[AW-1:0]),
    .wdata (b),
    .rdata (rdata)
  );

  // Format load data
  always_comb begin
    unique case (ld_op)
      OP_LB:   ld_data = {{24{rdata[31]}}, rdata[31:24]};
      OP_LH:   ld_data = {{16{rdata[31]}}, rdata[31:16]};
      default: ld_data = rdata;
    endcase
  end

  // Write back from the load stage or the execute stage
  always_comb begin
    rf_wr = '0;
    if (ld_fin) begin
      rf_wr.we   = !ld_bad;
      rf_wr.addr = ld_rt;
      rf_wr.data = ld_data;
    end else if (ex_fin) begin
      rf_wr = ex_wr;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      ex_valid  <= 1'b0;
      ld_valid  <= 1'b0;
      out_valid <= 1'b0;
      pc        <= CODE_START_RST;
      data_base <= DATA_BASE_RST;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (accept)                  ex_valid <= 1'b1;
      else if (ex_fin || ex_to_ld) ex_valid <= 1'b0;
      if (ex_to_ld)                ld_valid <= 1'b1;
      else if (ld_fin)             ld_valid <= 1'b0;
      if (ex_fin) begin
        out_valid <= 1'b1;
        pc        <= npc;
      end else if (ld_fin) begin
        out_valid <= 1'b1;
        pc        <= ld_npc;
      end
      if (cfg_write) begin
        if (cfg_index == CFG_CODE_START) pc <= cfg_data;
        else                             data_base <= cfg_data;
      end
    end
  end

  // Payload: instruction, load stage and result
  always_ff @(posedge clk) begin
    if (accept) ir <= instr_word;
    if (ex_to_ld) begin
      ld_rt  <= rt;
      ld_op  <= op;
      ld_bad <= bad;
      ld_npc <= seq;
    end
    if (ex_fin) begin
      next_pc     <= npc;
      print_valid <= pv;
      print_value <= pval;
      halted      <= halt;
      mem_fault   <= bad;
    end else if (ld_fin) begin
      next_pc     <= ld_npc;
      print_valid <= 1'b0;
      print_value <= '0;
      halted      <= 1'b0;
      mem_fault   <= ld_bad;
    end
  end

endmodule

`default_nettype wire
